>>> rtl/irt_pkg.sv
// Shared constants, status codes and tree sizing helpers for the interval reservation table.
package irt_pkg;

    // Default sizes
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_SEAT_BITS   = 32;
    localparam int DEF_OWNER_BITS  = 16;

    // Reduction tree fan-in (power of two)
    localparam int FANIN       = 16;
    localparam int FANIN_SHIFT = 4;

    // Request kinds
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;
    localparam logic [1:0] ST_FREE    = 2'd1;

    // Number of lanes left after a given number of tree levels
    function automatic int tree_count(input int n, input int levels);
        int c;
        begin
            c = n;
            for (int i = 0; i < 16; i++)
            begin
                if (i < levels)
                begin
                    c = (c + FANIN - 1) >> FANIN_SHIFT;
                end
            end
            return c;
        end
    endfunction

    // Registered levels needed to reduce n lanes to one
    function automatic int tree_levels(input int n);
        int c;
        int lv;
        begin
            c  = n;
            lv = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (c > 1)
                begin
                    c  = (c + FANIN - 1) >> FANIN_SHIFT;
                    lv = lv + 1;
                end
            end
            if (lv == 0)
            begin
                lv = 1;
            end
            return lv;
        end
    endfunction

endpackage

>>> rtl/irt_cell.sv
// One table slot: holds an interval, compares it against the request and shifts on insert.
module irt_cell #(
    parameter int SEAT_BITS  = irt_pkg::DEF_SEAT_BITS,
    parameter int OWNER_BITS = irt_pkg::DEF_OWNER_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request broadcast
    input  logic [SEAT_BITS-1:0]  req_lo,
    input  logic [SEAT_BITS-1:0]  req_hi,
    input  logic [OWNER_BITS-1:0] req_owner,
    input  logic                  commit,
    // lower neighbor
    input  logic                  prev_valid,
    input  logic                  prev_gt,
    input  logic [SEAT_BITS-1:0]  prev_start,
    input  logic [SEAT_BITS-1:0]  prev_end,
    input  logic [OWNER_BITS-1:0] prev_owner,
    // this slot, seen by the upper neighbor
    output logic                  valid,
    output logic                  gt,
    output logic [SEAT_BITS-1:0]  start_seat,
    output logic [SEAT_BITS-1:0]  end_seat,
    output logic [OWNER_BITS-1:0] owner,
    // registered compare result: {hit, owner masked by hit}
    output logic [OWNER_BITS:0]   lane
);

    logic                  valid_reg;
    logic [SEAT_BITS-1:0]  start_reg;
    logic [SEAT_BITS-1:0]  end_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [OWNER_BITS:0]   lane_reg;
    logic                  hit;
    logic                  take_prev;
    logic                  take_new;

    // Slot starts after the new interval, so it moves up on insert
    assign gt = valid_reg && (start_reg > req_lo);

    // Any shared seat with the request range
    assign hit = valid_reg && (start_reg <= req_hi) && (req_lo <= end_reg);

    // Neighbor moves in, or the new interval lands here
    assign take_prev = prev_gt;
    assign take_new  = !prev_gt && (gt || (!valid_reg && prev_valid));

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (commit && (take_prev || take_new))
        begin
            valid_reg <= 1'b1;
        end
    end

    // Shift or load interval contents
    always_ff @(posedge clk)
    begin
        if (commit && take_prev)
        begin
            start_reg <= prev_start;
            end_reg   <= prev_end;
            owner_reg <= prev_owner;
        end
        else if (commit && take_new)
        begin
            start_reg <= req_lo;
            end_reg   <= req_hi;
            owner_reg <= req_owner;
        end
    end

    // Register compare result for the reduction tree
    always_ff @(posedge clk)
    begin
        lane_reg <= {hit, owner_reg & {OWNER_BITS{hit}}};
    end

    assign valid      = valid_reg;
    assign start_seat = start_reg;
    assign end_seat   = end_reg;
    assign owner      = owner_reg;
    assign lane       = lane_reg;

endmodule

>>> rtl/irt_tree.sv
// Registered OR-reduction tree that merges the per-slot compare results.
module irt_tree #(
    parameter int LANES = irt_pkg::DEF_TABLE_DEPTH,
    parameter int LW    = irt_pkg::DEF_OWNER_BITS + 1
) (
    input  logic          clk,
    input  logic [LW-1:0] lane_in [LANES],
    output logic [LW-1:0] merged
);

    localparam int LEVELS = irt_pkg::tree_levels(LANES);

    logic [LW-1:0] node_reg [LEVELS][LANES];

    // One registered level per generate step, fan-in of FANIN
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        localparam int CNT_IN = irt_pkg::tree_count(LANES, l);
        if (l == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin : merge0
                logic [LW-1:0] acc;
                for (int j = 0; j < LANES; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < irt_pkg::FANIN; k++)
                    begin
                        if (j * irt_pkg::FANIN + k < CNT_IN)
                        begin
                            acc = acc | lane_in[j * irt_pkg::FANIN + k];
                        end
                    end
                    node_reg[l][j] <= acc;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin : merge_n
                logic [LW-1:0] acc;
                for (int j = 0; j < LANES; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < irt_pkg::FANIN; k++)
                    begin
                        if (j * irt_pkg::FANIN + k < CNT_IN)
                        begin
                            acc = acc | node_reg[l-1][j * irt_pkg::FANIN + k];
                        end
                    end
                    node_reg[l][j] <= acc;
                end
            end
        end
    end

    assign merged = node_reg[LEVELS-1][0];

endmodule

>>> rtl/interval_reservation_table_core.sv
// Steps: the request is registered, the slot compare result is registered in S_CMP, then the L
// registered levels of the OR tree run in S_RED, L = ceil(log16(TABLE_DEPTH)), and the result is
// registered in S_DONE; a request is taken only in S_IDLE, so a held result blocks intake.
// Inserts shift the slot chain in the cycle the result is registered.
// Reset (rst_n low, asynchronous) empties the table and clears the output register;
// slot contents are not cleared.
module interval_reservation_table_core #(
    parameter int TABLE_DEPTH = irt_pkg::DEF_TABLE_DEPTH,
    parameter int SEAT_BITS   = irt_pkg::DEF_SEAT_BITS,
    parameter int OWNER_BITS  = irt_pkg::DEF_OWNER_BITS,
    localparam int IN_W       = ((2 * SEAT_BITS + OWNER_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 + OWNER_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // start_seat, end_seat, owner_id
    input  logic [0:0]       s_tuser,   // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, holder_id
);

    localparam int LEVELS = irt_pkg::tree_levels(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RED_W  = $clog2(LEVELS + 1);
    localparam int LW     = OWNER_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [RED_W-1:0]      red_cnt_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [OWNER_BITS-1:0] out_holder_reg;

    logic                  req_action_reg;
    logic [SEAT_BITS-1:0]  req_lo_reg;
    logic [SEAT_BITS-1:0]  req_hi_reg;
    logic [OWNER_BITS-1:0] req_owner_reg;

    logic                  in_xfer;
    logic                  out_load;
    logic                  commit;
    logic                  ins_ok;
    logic [1:0]            status_next;
    logic [OWNER_BITS-1:0] holder_next;
    logic                  table_full;
    logic [LW-1:0]         merged;
    logic                  any_hit;
    logic [OWNER_BITS-1:0] hit_owner;

    logic                  c_valid [TABLE_DEPTH];
    logic                  c_gt    [TABLE_DEPTH];
    logic [SEAT_BITS-1:0]  c_start [TABLE_DEPTH];
    logic [SEAT_BITS-1:0]  c_end   [TABLE_DEPTH];
    logic [OWNER_BITS-1:0] c_owner [TABLE_DEPTH];
    logic [LW-1:0]         c_lane  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Capture request; a query compares against the one-seat range [seat, seat]
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_action_reg <= s_tuser[0];
            req_lo_reg     <= s_tdata[SEAT_BITS-1:0];
            req_owner_reg  <= s_tdata[2*SEAT_BITS+OWNER_BITS-1:2*SEAT_BITS];
            if (s_tuser[0] == irt_pkg::ACT_QUERY)
            begin
                req_hi_reg <= s_tdata[SEAT_BITS-1:0];
            end
            else
            begin
                req_hi_reg <= s_tdata[2*SEAT_BITS-1:SEAT_BITS];
            end
        end
    end

    // Slot chain
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            irt_cell #(
                .SEAT_BITS (SEAT_BITS),
                .OWNER_BITS(OWNER_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .req_lo    (req_lo_reg),
                .req_hi    (req_hi_reg),
                .req_owner (req_owner_reg),
                .commit    (commit),
                .prev_valid(1'b1),
                .prev_gt   (1'b0),
                .prev_start('0),
                .prev_end  ('0),
                .prev_owner('0),
                .valid     (c_valid[i]),
                .gt        (c_gt[i]),
                .start_seat(c_start[i]),
                .end_seat  (c_end[i]),
                .owner     (c_owner[i]),
                .lane      (c_lane[i])
            );
        end
        else
        begin : g_body
            irt_cell #(
                .SEAT_BITS (SEAT_BITS),
                .OWNER_BITS(OWNER_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .req_lo    (req_lo_reg),
                .req_hi    (req_hi_reg),
                .req_owner (req_owner_reg),
                .commit    (commit),
                .prev_valid(c_valid[i-1]),
                .prev_gt   (c_gt[i-1]),
                .prev_start(c_start[i-1]),
                .prev_end  (c_end[i-1]),
                .prev_owner(c_owner[i-1]),
                .valid     (c_valid[i]),
                .gt        (c_gt[i]),
                .start_seat(c_start[i]),
                .end_seat  (c_end[i]),
                .owner     (c_owner[i]),
                .lane      (c_lane[i])
            );
        end
        assign valid_vec[i] = c_valid[i];
    end

    // Merge compare results
    irt_tree #(
        .LANES(TABLE_DEPTH),
        .LW   (LW)
    ) u_tree (
        .clk    (clk),
        .lane_in(c_lane),
        .merged (merged)
    );

    assign any_hit    = merged[LW-1];
    assign hit_owner  = merged[OWNER_BITS-1:0];
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    // Decide status
    always_comb
    begin
        status_next = irt_pkg::ST_OK;
        holder_next = '0;
        ins_ok      = 1'b0;
        priority if (req_action_reg == irt_pkg::ACT_QUERY)
        begin
            if (any_hit)
            begin
                status_next = irt_pkg::ST_OK;
                holder_next = hit_owner;
            end
            else
            begin
                status_next = irt_pkg::ST_FREE;
            end
        end
        else if (req_lo_reg > req_hi_reg)
        begin
            status_next = irt_pkg::ST_BAD;
        end
        else if (any_hit)
        begin
            status_next = irt_pkg::ST_OVERLAP;
        end
        else if (table_full)
        begin
            status_next = irt_pkg::ST_FULL;
        end
        else
        begin
            status_next = irt_pkg::ST_OK;
            ins_ok      = 1'b1;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign commit   = out_load && ins_ok;

    // Sequence the request and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            red_cnt_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_holder_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_next;
                out_holder_reg <= holder_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    red_cnt_reg <= '0;
                    state_reg   <= S_RED;
                end
                S_RED:
                begin
                    if (red_cnt_reg == RED_W'(LEVELS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        red_cnt_reg <= red_cnt_reg + RED_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_holder_reg, out_status_reg});

`ifndef NO_ASSERTIONS
    // Occupied slots always match the entry count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("slot valid flags disagree with entry count");

    // Never insert into a full table
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !table_full)
        else $error("insert committed into a full table");

    // A committed insert grows the table by exactly one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count did not advance after insert");

    // A new result only appears out of the decide state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result presented without a finished request");
`endif

endmodule

>>> test/interval_reservation_table_core_tb.sv
// Self-checking testbench for the interval reservation table core.
`timescale 1ns / 1ps

module interval_reservation_table_core_tb;

    localparam int DEPTH        = irt_pkg::DEF_TABLE_DEPTH;
    localparam int SEAT_W       = irt_pkg::DEF_SEAT_BITS;
    localparam int OWNER_W      = irt_pkg::DEF_OWNER_BITS;
    localparam int IN_W         = ((2 * SEAT_W + OWNER_W + 7) / 8) * 8;
    localparam int OUT_W        = ((2 + OWNER_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1675;
    localparam int RANDOM_CAP   = 2000;
    localparam int PHASE_LEN    = 400;
    localparam int FULL_WANTED  = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT    = 1000000;

    // Short names for the request kinds in the directed table
    localparam logic INS = irt_pkg::ACT_INSERT;
    localparam logic QRY = irt_pkg::ACT_QUERY;

    // Idling phases
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_SINK   = 2;
    localparam int IDLE_BOTH   = 3;

    typedef struct {
        logic              act;
        logic [SEAT_W-1:0] lo;
        logic [SEAT_W-1:0] hi;
        logic [OWNER_W-1:0] who;
        bit                fixed;
        logic [1:0]        x_status;
        logic [OWNER_W-1:0] x_holder;
    } seat_req_t;

    typedef struct {
        logic [1:0]         status;
        logic [OWNER_W-1:0] holder;
    } seat_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;    // start_seat, end_seat, owner_id
    logic [0:0]        s_tuser = '0;    // action
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // status, holder_id

    // Shadow copy of the seat table
    logic [SEAT_W-1:0]  tbl_lo [DEPTH];
    logic [SEAT_W-1:0]  tbl_hi [DEPTH];
    logic [OWNER_W-1:0] tbl_who [DEPTH];
    int                 pred_fill = 0;

    seat_req_t    cur_req;
    seat_req_t    dir_rows [$];
    seat_answer_t owed_answers [$];

    int idle_mode = IDLE_NONE;
    int errors = 0;
    int cycle_count = 0;
    int n_booked = 0;
    int n_overlap = 0;
    int n_full = 0;
    int n_bad = 0;
    int n_found = 0;
    int n_free = 0;
    int rand_count = 0;

    interval_reservation_table_core #(
        .TABLE_DEPTH (DEPTH),
        .SEAT_BITS   (SEAT_W),
        .OWNER_BITS  (OWNER_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Book an interval or look up one seat in the shadow table
    function automatic seat_answer_t seat_table_answer(seat_req_t r);
        seat_answer_t a;
        bit           clash;
        int           pos;
        begin
            a.status = irt_pkg::ST_OK;
            a.holder = '0;
            if (r.act == irt_pkg::ACT_QUERY)
            begin
                a.status = irt_pkg::ST_FREE;
                for (int k = 0; k < pred_fill; k++)
                begin
                    if (a.status == irt_pkg::ST_FREE &&
                        tbl_lo[k] <= r.lo && r.lo <= tbl_hi[k])
                    begin
                        a.status = irt_pkg::ST_OK;
                        a.holder = tbl_who[k];
                    end
                end
            end
            else if (r.lo > r.hi)
            begin
                a.status = irt_pkg::ST_BAD;
            end
            else
            begin
                clash = 1'b0;
                pos   = 0;
                for (int k = 0; k < pred_fill; k++)
                begin
                    if (tbl_lo[k] <= r.hi && r.lo <= tbl_hi[k])
                        clash = 1'b1;
                    if (tbl_lo[k] < r.lo)
                        pos++;
                end
                if (clash)
                    a.status = irt_pkg::ST_OVERLAP;
                else if (pred_fill >= DEPTH)
                    a.status = irt_pkg::ST_FULL;
                else
                begin
                    // Open a slot at the sorted place and shift the rest up
                    for (int k = pred_fill; k > pos; k--)
                    begin
                        tbl_lo[k]  = tbl_lo[k-1];
                        tbl_hi[k]  = tbl_hi[k-1];
                        tbl_who[k] = tbl_who[k-1];
                    end
                    tbl_lo[pos]  = r.lo;
                    tbl_hi[pos]  = r.hi;
                    tbl_who[pos] = r.who;
                    pred_fill    = pred_fill + 1;
                end
            end
            return a;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        begin
            errors++;
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    task automatic add_row(input logic act, input logic [SEAT_W-1:0] lo,
                           input logic [SEAT_W-1:0] hi, input logic [OWNER_W-1:0] who,
                           input bit fixed, input logic [1:0] st,
                           input logic [OWNER_W-1:0] holder);
        seat_req_t r;
        begin
            r.act      = act;
            r.lo       = lo;
            r.hi       = hi;
            r.who      = who;
            r.fixed    = fixed;
            r.x_status = st;
            r.x_holder = holder;
            dir_rows.push_back(r);
        end
    endtask

    // Random request, mostly bookings spread over 2048 seat blocks so the table fills
    function automatic seat_req_t draw_request();
        seat_req_t         r;
        int unsigned       pick;
        int unsigned       k;
        logic [SEAT_W-1:0] lo;
        logic [SEAT_W-1:0] hi;
        logic [SEAT_W-1:0] d;
        begin
            r.act      = irt_pkg::ACT_INSERT;
            r.fixed    = 1'b0;
            r.x_status = irt_pkg::ST_OK;
            r.x_holder = '0;
            r.who      = OWNER_W'($urandom_range(16'hFFFF));
            r.hi       = $urandom;
            pick       = $urandom_range(99);
            d          = SEAT_W'($urandom_range(64, 1));
            if (pred_fill > 0)
            begin
                k  = $urandom_range(pred_fill - 1);
                lo = tbl_lo[k];
                hi = tbl_hi[k];
            end
            else
            begin
                lo = $urandom;
                hi = lo;
            end
            if (pick < 68)
            begin
                r.lo = {11'($urandom_range(2047)), 21'($urandom_range(20'hFFFFF))};
                case ($urandom_range(9))
                    0:       r.hi = r.lo;
                    1, 2:    r.hi = r.lo + SEAT_W'($urandom_range(20'hFFFFF));
                    default: r.hi = r.lo + SEAT_W'($urandom_range(4095));
                endcase
            end
            else if (pick < 74)
            begin
                // Probe the edges of a held interval
                case ($urandom_range(5))
                    0:       begin r.lo = lo - d;            r.hi = lo;     end
                    1:       begin r.lo = hi;                r.hi = hi + d; end
                    2:       begin r.lo = lo + (hi - lo) / 2; r.hi = r.lo;  end
                    3:       begin r.lo = lo - d;            r.hi = hi + d; end
                    4:       begin r.lo = hi + 1;            r.hi = hi + d; end
                    default: begin r.lo = lo - d;            r.hi = lo - 1; end
                endcase
            end
            else if (pick < 77)
            begin
                r.lo = $urandom;
                if (r.lo == '0)
                    r.lo = 1;
                r.hi = $urandom_range(r.lo - 1);
            end
            else if (pick < 79)
            begin
                lo   = $urandom;
                hi   = $urandom;
                r.lo = (lo < hi) ? lo : hi;
                r.hi = (lo < hi) ? hi : lo;
            end
            else
            begin
                r.act = irt_pkg::ACT_QUERY;
                case ($urandom_range(5))
                    0:       r.lo = lo;
                    1:       r.lo = hi;
                    2:       r.lo = lo + SEAT_W'($urandom_range(hi - lo));
                    3:       r.lo = lo - 1;
                    4:       r.lo = hi + 1;
                    default: r.lo = $urandom;
                endcase
            end
            return r;
        end
    endfunction

    // Drive one request and hold it until the transfer
    task automatic push_request(input seat_req_t r);
        begin
            while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 88) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 32))
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {r.who, r.hi, r.lo};
            s_tuser  <= r.act;
            cur_req  <= r;
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    // Stall the result side according to the phase
    always @(posedge clk)
    begin
        m_tready <= !((idle_mode == IDLE_SINK && $urandom_range(99) < 88) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 32));
    end

    // Predict on request transfers, check on result transfers
    always @(posedge clk)
    begin
        seat_answer_t a;
        seat_answer_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                a = seat_table_answer(cur_req);
                if (cur_req.act == irt_pkg::ACT_QUERY)
                begin
                    if (a.status == irt_pkg::ST_OK) n_found++; else n_free++;
                end
                else
                begin
                    case (a.status)
                        irt_pkg::ST_OK:      n_booked++;
                        irt_pkg::ST_OVERLAP: n_overlap++;
                        irt_pkg::ST_FULL:    n_full++;
                        default:             n_bad++;
                    endcase
                end
                if (cur_req.fixed)
                begin
                    a.status = cur_req.x_status;
                    a.holder = cur_req.x_holder;
                end
                owed_answers.push_back(a);
            end
            if (m_tvalid && m_tready)
            begin
                if (owed_answers.size() == 0)
                    report_mismatch("unexpected result", '0, 32'(m_tdata));
                else
                begin
                    want = owed_answers.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_tdata[1:0]));
                    if (m_tdata[2 +: OWNER_W] !== want.holder)
                        report_mismatch("holder_id", 32'(want.holder),
                                        32'(m_tdata[2 +: OWNER_W]));
                end
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("interval_reservation_table_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        // Directed rows: empty table, range extremes, adjacency and overlap shapes
        add_row(QRY, 32'h0000_0000, 32'hDEAD_BEEF, 16'h7777, 1, irt_pkg::ST_FREE, 16'h0000);
        add_row(QRY, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 1, irt_pkg::ST_FREE, 16'h0000);
        add_row(INS, 32'h0000_000A, 32'h0000_0005, 16'h1111, 1, irt_pkg::ST_BAD,  16'h0000);
        add_row(INS, 32'hFFFF_FFFF, 32'h0000_0000, 16'h2222, 1, irt_pkg::ST_BAD,  16'h0000);
        add_row(INS, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_0100, 32'h0000_01FF, 16'h1234, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_0200, 32'h0000_02FF, 16'hABCD, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_00F0, 32'h0000_00FF, 16'h5555, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_01FF, 32'h0000_0200, 16'h3333, 1, irt_pkg::ST_OVERLAP, 16'h0000);
        add_row(INS, 32'h0000_0150, 32'h0000_0160, 16'h4444, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_0080, 32'h0000_0400, 16'h6666, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'h0000_0000, 32'hFFFF_FFFF, 16'h8888, 1, irt_pkg::ST_OVERLAP, 16'h0000);
        add_row(INS, 32'h0000_0180, 32'h0000_0170, 16'h9999, 1, irt_pkg::ST_BAD,  16'h0000);
        add_row(INS, 32'h0000_1000, 32'h0000_1000, 16'h0000, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_0100, 32'h1234_5678, 16'hA5A5, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_02FF, 32'h8765_4321, 16'h5A5A, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_0300, 32'hFFFF_FFFF, 16'hFFFF, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_00EF, 32'h0000_0000, 16'h0000, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_0000, 32'h0F0F_0F0F, 16'h00FF, 1, irt_pkg::ST_OK,   16'hFFFF);
        add_row(QRY, 32'hFFFF_FFFF, 32'hF0F0_F0F0, 16'hFF00, 1, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'h0000_1000, 32'h0000_0001, 16'h0001, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'hFFFF_FFFE, 32'h0000_0002, 16'h8000, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(INS, 32'hFFFF_0000, 32'hFFFF_FFFE, 16'h8000, 0, irt_pkg::ST_OK,   16'h0000);
        add_row(QRY, 32'hFFFF_8000, 32'hCAFE_F00D, 16'h7FFF, 0, irt_pkg::ST_OK,   16'h0000);

        // Hold reset, then release at a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        idle_mode = IDLE_NONE;
        foreach (dir_rows[i])
            push_request(dir_rows[i]);

        // Random traffic until the table has filled and overflowed a while, or RANDOM_CAP is reached
        while ((rand_count < RANDOM_ITEMS || pred_fill < DEPTH || n_full < FULL_WANTED)
               && rand_count < RANDOM_CAP)
        begin
            idle_mode = (rand_count / PHASE_LEN) % 4;
            push_request(draw_request());
            rand_count++;
        end
        s_tvalid  <= 1'b0;
        idle_mode = IDLE_NONE;

        // Drain the outstanding results
        while (owed_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d booked, %0d overlaps, %0d full, %0d bad ranges",
                 dir_rows.size() + rand_count, n_booked, n_overlap, n_full, n_bad);
        $display("lookups: %0d held seats, %0d free seats; table ended with %0d of %0d entries",
                 n_found, n_free, pred_fill, DEPTH);
        if (errors == 0)
            $display("interval_reservation_table_core regression: pass");
        else
            $display("interval_reservation_table_core regression: fail");
        $finish;
    end

endmodule
